// File: hdl/adp_xor_of_three_sums_macros.svh
// Assertion macros for the adp_xor_of_three_sums block.
`ifndef ADP_XOR_OF_THREE_SUMS_MACROS_SVH
`define ADP_XOR_OF_THREE_SUMS_MACROS_SVH
`ifndef SYNTH
`define ADP_ASSERT_SAME(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define ADP_ASSERT_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ADP_ASSERT_SAME(lbl, clk, rstn, a, c)
`define ADP_ASSERT_NEXT(lbl, clk, rstn, a, c)
`endif
`endif

// File: hdl/adp_pkg.sv
// Shared constants, types and the per-bit transition function.
package adp_pkg;
    localparam int WORD_BITS = 32;
    localparam int NUM_STATES = 128;
    localparam int ST_W = 7;
    localparam int POS_W = 5;
    localparam int CNT_W = 33;
    localparam logic [ST_W-1:0] START_STATE = 7'd64;
    localparam logic [ST_W-1:0] LAST_STATE = 7'd127;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(WORD_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_SUM,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic             load;      // capture request, reset banks
        logic             rd;        // read phase of a transition
        logic             wr;        // write phase of a transition
        logic             swap;      // bit position done, swap banks
        logic             first;     // position zero: counts come from start vector
        logic             sum_rd;    // read phase of final sweep
        logic             sum_acc;   // accumulate phase of final sweep
        logic             out_load;  // move total to output register
        logic [POS_W-1:0] pos;
        logic [ST_W-1:0]  st;
        logic             xbit;
    } adp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } adp_status_t;

    // One step: returns {dbit, next state}.
    function automatic logic [ST_W:0] adp_advance(input logic [ST_W-1:0] st,
                                                  input logic a, input logic k0,
                                                  input logic k1, input logic dl,
                                                  input logic da);
        logic x1, y1, z1, x2, y2, z2;
        logic n1, n2, n3, n4, n5, n6;
        logic [1:0] sb;
        x1 = a ^ k0 ^ st[0];
        n1 = (a & k0) | (a & st[0]) | (k0 & st[0]);
        y1 = a ^ k1 ^ st[1];
        n2 = (a & k1) | (a & st[1]) | (k1 & st[1]);
        z1 = a ^ dl ^ st[2];
        n3 = (a & dl) | (a & st[2]) | (dl & st[2]);
        x2 = x1 ^ da ^ st[3];
        n4 = (x1 & da) | (x1 & st[3]) | (da & st[3]);
        y2 = y1 ^ da ^ st[4];
        n5 = (y1 & da) | (y1 & st[4]) | (da & st[4]);
        z2 = z1 ^ da ^ st[5];
        n6 = (z1 & da) | (z1 & st[5]) | (da & st[5]);
        // signed sum plus one, taken mod 4
        sb = 2'({1'b0, x2 ^ y2 ^ z2}) + 2'({1'b0, st[6]}) + 2'd1
           - 2'({1'b0, x1 ^ y1 ^ z1});
        return {sb[0], sb[1], n6, n5, n4, n3, n2, n1};
    endfunction
endpackage

// File: hdl/adp_ctrl.sv
// Controller: walks positions, states and x bits, then the final sweep.
`include "adp_xor_of_three_sums_macros.svh"
module adp_ctrl
    import adp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  adp_status_t status,
    output adp_cmd_t    cmd
);
    ctrl_state_t      state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [ST_W-1:0]  st_reg, st_next;
    logic             a_reg, a_next;
    logic             ph_reg, ph_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            st_reg    <= '0;
            a_reg     <= 1'b0;
            ph_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            st_reg    <= st_next;
            a_reg     <= a_next;
            ph_reg    <= ph_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        st_next    = st_reg;
        a_next     = a_reg;
        ph_next    = ph_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.pos    = pos_reg;
        cmd.st     = st_reg;
        cmd.xbit   = a_reg;
        cmd.first  = (pos_reg == '0);
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                    pos_next   = '0;
                    st_next    = '0;
                    a_next     = 1'b0;
                    ph_next    = 1'b0;
                end
            end
            ST_RUN: begin
                ph_next = ~ph_reg;
                if (!ph_reg) begin
                    cmd.rd = 1'b1;
                end else begin
                    cmd.wr = 1'b1;
                    a_next = ~a_reg;
                    if (a_reg) begin
                        st_next = st_reg + 1'b1;
                        if (st_reg == LAST_STATE) begin
                            cmd.swap = 1'b1;
                            pos_next = pos_reg + 1'b1;
                            if (pos_reg == LAST_POS) begin
                                pos_next   = '0;
                                state_next = ST_SUM;
                            end
                        end
                    end
                end
            end
            ST_SUM: begin
                cmd.first = 1'b0;
                ph_next   = ~ph_reg;
                if (!ph_reg) begin
                    cmd.sum_rd = 1'b1;
                end else begin
                    cmd.sum_acc = 1'b1;
                    st_next     = st_reg + 1'b1;
                    if (st_reg == LAST_STATE) begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ADP_ASSERT_SAME(a_rd_wr_excl, aclk, aresetn, cmd.rd, !cmd.wr && !cmd.sum_acc)
    `ADP_ASSERT_NEXT(a_sum_start, aclk, aresetn,
        state_reg == ST_RUN && state_next == ST_SUM, st_reg == '0 && !ph_reg)
    `ADP_ASSERT_SAME(a_load_idle, aclk, aresetn, cmd.load, state_reg == ST_IDLE)
endmodule

// File: hdl/adp_datapath.sv
// Datapath: operand registers, two count banks, transition logic, total.
module adp_datapath
    import adp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [159:0]  s_tdata,
    input  adp_cmd_t      cmd,
    output adp_status_t   status,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [39:0]   m_tdata
);
    logic [WORD_BITS-1:0] k0_reg, k1_reg, dl_reg, da_reg, db_reg;
    logic [CNT_W-1:0]     mem0 [NUM_STATES];
    logic [CNT_W-1:0]     mem1 [NUM_STATES];
    logic [NUM_STATES-1:0] vld0_reg, vld1_reg;
    logic                 sel_reg;
    logic [CNT_W-1:0]     rd0_reg, rd1_reg;
    logic                 rv0_reg, rv1_reg;
    logic [ST_W-1:0]      nx_reg;
    logic                 match_reg, start_reg, first_reg;
    logic [CNT_W-1:0]     total_reg;
    logic                 m_tvalid_reg;
    logic [CNT_W-1:0]     m_data_reg;

    logic [ST_W:0]        adv;
    logic [ST_W-1:0]      addr0, addr1;
    logic [CNT_W-1:0]     cur_val, nxt_val, sum_val;

    assign adv = adp_advance(cmd.st, cmd.xbit, k0_reg[cmd.pos], k1_reg[cmd.pos],
                             dl_reg[cmd.pos], da_reg[cmd.pos]);
    // bank 0 is current when sel is low
    assign addr0 = sel_reg ? adv[ST_W-1:0] : cmd.st;
    assign addr1 = sel_reg ? cmd.st : adv[ST_W-1:0];

    always_comb begin
        if (first_reg) begin
            cur_val = start_reg ? CNT_W'(1) : '0;
        end else if (sel_reg) begin
            cur_val = rv1_reg ? rd1_reg : '0;
        end else begin
            cur_val = rv0_reg ? rd0_reg : '0;
        end
        nxt_val = sel_reg ? (rv0_reg ? rd0_reg : '0) : (rv1_reg ? rd1_reg : '0);
        sum_val = nxt_val + (match_reg ? cur_val : '0);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            k0_reg <= s_tdata[31:0];
            k1_reg <= s_tdata[63:32];
            dl_reg <= s_tdata[95:64];
            da_reg <= s_tdata[127:96];
            db_reg <= s_tdata[159:128];
        end
        if (cmd.rd || cmd.sum_rd) begin
            rd0_reg   <= mem0[addr0];
            rd1_reg   <= mem1[addr1];
            rv0_reg   <= vld0_reg[addr0];
            rv1_reg   <= vld1_reg[addr1];
            nx_reg    <= adv[ST_W-1:0];
            match_reg <= (adv[ST_W] == db_reg[cmd.pos]);
            start_reg <= (cmd.st == START_STATE);
            first_reg <= cmd.first;
        end
        if (cmd.wr && sel_reg) begin
            mem0[nx_reg] <= sum_val;
        end
        if (cmd.wr && !sel_reg) begin
            mem1[nx_reg] <= sum_val;
        end
        if (cmd.load) begin
            total_reg <= '0;
        end else if (cmd.sum_acc) begin
            total_reg <= total_reg + cur_val;
        end
        if (cmd.out_load) begin
            m_data_reg <= total_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld0_reg     <= '0;
            vld1_reg     <= '0;
            sel_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                vld0_reg <= '0;
                vld1_reg <= '0;
                sel_reg  <= 1'b0;
            end else begin
                if (cmd.wr && sel_reg) begin
                    vld0_reg[nx_reg] <= 1'b1;
                end
                if (cmd.wr && !sel_reg) begin
                    vld1_reg[nx_reg] <= 1'b1;
                end
                if (cmd.swap) begin
                    sel_reg <= ~sel_reg;
                    // old current bank becomes next bank: empty it
                    if (sel_reg) begin
                        vld1_reg <= '0;
                    end else begin
                        vld0_reg <= '0;
                    end
                end
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign status.out_busy = m_tvalid_reg && !m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = {7'd0, m_data_reg};
endmodule

// File: hdl/adp_xor_of_three_sums.sv
// Top level: additive differential count of the xor of three sums.
// channel  dir  tdata fields (low bit up)
// s_       in   first_key[31:0] second_key[63:32] round_constant[95:64]
//               input_difference[127:96] output_difference[159:128]
// m_       out  solution_count[32:0], zero pad [39:33]
// Order: one request walks 2*128*32 = 8192 transitions
// (one read and one read-modify-write of a count bank per transition),
// then the final sum over 128 states.
// Reset: aresetn synchronous, active low; no clearing pass, banks use valid bits.
// Stalls: the result waits in the output register; a new request is taken
// once the block is back in idle.
module adp_xor_of_three_sums
    import adp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,   // first_key, second_key, round_constant,
                                    // input_difference, output_difference
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata    // solution_count, zero pad
);
    adp_cmd_t    cmd;
    adp_status_t status;

    adp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    adp_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );
endmodule

// File: sim/adp_xor_of_three_sums_tb.sv
// Testbench for adp_xor_of_three_sums: directed table plus random requests, predicted counts.
module adp_xor_of_three_sums_tb;
    import adp_pkg::*;

    typedef struct packed {
        logic [31:0] out_diff;
        logic [31:0] in_diff;
        logic [31:0] rconst;
        logic [31:0] key1;
        logic [31:0] key0;
    } request_t;

    typedef struct {
        request_t    req;
        logic        has_exp;
        logic [32:0] exp_count;
    } dir_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [159:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;

    logic [32:0]  count_queue[$];
    int           error_count;
    int           send_idle_pct;
    int           recv_idle_pct;
    bit           hold_off;

    adp_xor_of_three_sums uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // Path count over carry/borrow states, walked from the lsb.
    function automatic logic [32:0] count_solutions(request_t r);
        logic [32:0] cur[NUM_STATES];
        logic [32:0] nxt[NUM_STATES];
        logic [32:0] total;
        logic [5:0]  cy, ncy;
        logic        brw, nbrw;
        logic        k0, k1, dl, da, db, x1, y1, z1, x2, y2, z2;
        int          s;
        for (int i = 0; i < NUM_STATES; i++) cur[i] = '0;
        cur[64] = 33'd1;
        for (int p = 0; p < 32; p++) begin
            k0 = r.key0[p]; k1 = r.key1[p]; dl = r.rconst[p];
            da = r.in_diff[p]; db = r.out_diff[p];
            for (int i = 0; i < NUM_STATES; i++) nxt[i] = '0;
            for (int st = 0; st < NUM_STATES; st++) begin
                if (cur[st] != 0) begin
                    for (int a = 0; a < 2; a++) begin
                        cy = st[5:0];
                        brw = st[6];
                        x1 = a[0] ^ k0 ^ cy[0]; ncy[0] = (a[0] + k0 + cy[0]) > 1;
                        y1 = a[0] ^ k1 ^ cy[1]; ncy[1] = (a[0] + k1 + cy[1]) > 1;
                        z1 = a[0] ^ dl ^ cy[2]; ncy[2] = (a[0] + dl + cy[2]) > 1;
                        x2 = x1 ^ da ^ cy[3]; ncy[3] = (x1 + da + cy[3]) > 1;
                        y2 = y1 ^ da ^ cy[4]; ncy[4] = (y1 + da + cy[4]) > 1;
                        z2 = z1 ^ da ^ cy[5]; ncy[5] = (z1 + da + cy[5]) > 1;
                        s = int'(x2 ^ y2 ^ z2) - int'(x1 ^ y1 ^ z1) + int'(brw) + 1;
                        nbrw = s >= 2;
                        if (s[0] == db)
                            nxt[{nbrw, ncy}] = nxt[{nbrw, ncy}] + cur[st];
                    end
                end
            end
            cur = nxt;
        end
        total = '0;
        for (int i = 0; i < NUM_STATES; i++) total = total + cur[i];
        return total;
    endfunction

    task automatic report_mismatch(string what, logic [32:0] got, logic [32:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic send_request(request_t r, logic has_exp, logic [32:0] exp_count);
        logic [32:0] pred;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        pred = count_solutions(r);
        if (has_exp && pred !== exp_count) report_mismatch("table entry", pred, exp_count);
        s_tvalid <= 1'b1;
        s_tdata <= r;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        count_queue.push_back(has_exp ? exp_count : pred);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(4))
            0: return '0;
            1: return '1;
            2: return 32'h1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    // receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (count_queue.size() == 0) begin
                    report_mismatch("unexpected transaction", m_tdata[32:0], 33'h0);
                end else begin
                    logic [32:0] want;
                    want = count_queue.pop_front();
                    if (m_tdata[32:0] !== want) report_mismatch("solution_count", m_tdata[32:0], want);
                end
            end
            m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        hold_off = 1'b0;
        @(posedge aresetn);
        repeat (25000) @(posedge aclk);
        hold_off = 1'b1;
        repeat (60000) @(posedge aclk);
        hold_off = 1'b0;
    end

    initial begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        dir_row_t table_rows[$];
        request_t r;
        error_count = 0;
        send_idle_pct = 15;
        recv_idle_pct = 60;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // zero differences always hold for every x
        table_rows.push_back('{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, 33'h1_0000_0000});
        table_rows.push_back('{'{32'h0, 32'h0, '1, '1, '1}, 1'b1, 33'h1_0000_0000});
        // zero input difference with a nonzero output difference never holds
        table_rows.push_back('{'{32'h1, 32'h0, 32'h5, 32'h3, 32'h7}, 1'b1, 33'h0});
        table_rows.push_back('{'{'1, 32'h0, '1, '1, '1}, 1'b1, 33'h0});
        table_rows.push_back('{'{32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 32'h0}, 1'b0, 33'h0});
        table_rows.push_back('{'{'1, '1, '1, '1, '1}, 1'b0, 33'h0});
        table_rows.push_back('{'{32'h1, 32'h1, 32'h0, 32'h0, 32'h0}, 1'b0, 33'h0});
        table_rows.push_back('{'{32'h1, 32'h1, 32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f}, 1'b0, 33'h0});
        table_rows.push_back('{'{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'hffff_0000}, 1'b0, 33'h0});
        table_rows.push_back('{'{32'haaaa_aaaa, 32'h5555_5555, '1, 32'h0, 32'h8000_0000}, 1'b0, 33'h0});
        table_rows.push_back('{'{32'h8000_0000, 32'h1, 32'h0, '1, 32'h1}, 1'b0, 33'h0});
        foreach (table_rows[i]) send_request(table_rows[i].req, table_rows[i].has_exp, table_rows[i].exp_count);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 60 : 0;
            recv_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 15 : 0;
            for (int n = 0; n < 30; n++) begin
                r.key0 = rand_word(); r.key1 = rand_word(); r.rconst = rand_word();
                r.in_diff = rand_word();
                // half the time output differences near the input one, where counts are nonzero
                r.out_diff = ($urandom_range(1)) ? r.in_diff ^ (32'h1 << $urandom_range(31))
                                                 : rand_word();
                send_request(r, 1'b0, 33'h0);
            end
        end
        s_tvalid <= 1'b0;

        while (count_queue.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+hdl
hdl/adp_pkg.sv
hdl/adp_ctrl.sv
hdl/adp_datapath.sv
hdl/adp_xor_of_three_sums.sv
sim/adp_xor_of_three_sums_tb.sv
